// ===== src/homogeneous_travel_time_and_gradient_unit_macros.svh =====
`ifndef HOMOGENEOUS_TRAVEL_TIME_AND_GRADIENT_UNIT_MACROS_SVH
`define HOMOGENEOUS_TRAVEL_TIME_AND_GRADIENT_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HTT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/htt_pkg.sv =====
package htt_pkg;

    localparam int IDX_W        = 10;
    localparam int REG_W        = 32;
    localparam int AXES         = 3;
    localparam int GRID_DIM_MAX = 1024;

    localparam int POS_W     = IDX_W + REG_W;        // node position, Q30.12
    localparam int SPLIT_W   = 32;                   // low slice of split products
    localparam int HI_W      = POS_W - SPLIT_W;
    localparam int SQ_W      = 2 * POS_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int DIST_W    = SUM_W / 2;
    localparam int DHI_W     = DIST_W - SPLIT_W;
    localparam int NUM_W     = POS_W + REG_W;        // offset times slowness
    localparam int QUO_W     = REG_W;
    localparam int TT_PROD_W = DIST_W + REG_W;
    localparam int TT_SHIFT  = 28;
    localparam int TT_W      = 48;
    localparam int GRAD_W    = REG_W + 1;

    localparam int IN_DATA_W  = ((AXES * IDX_W + 7) / 8) * 8;
    localparam int OUT_BITS   = TT_W + AXES * GRAD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_ADDR_W = 3;

    localparam logic [REG_W-1:0] SPACING_RESET = 32'd4096;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SRC_X    = 3'd0,
        CFG_SRC_Y    = 3'd1,
        CFG_SRC_Z    = 3'd2,
        CFG_SPC_X    = 3'd3,
        CFG_SPC_Y    = 3'd4,
        CFG_SPC_Z    = 3'd5,
        CFG_SLOWNESS = 3'd6
    } cfg_idx_t;

endpackage

// ===== src/htt_isqrt.sv =====
module htt_isqrt #(
    parameter int RAD_W  = htt_pkg::SUM_W,
    parameter int ROOT_W = RAD_W / 2,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] side_out
);
    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic [ROOT_W-1:0] valid_reg;

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        logic [RAD_W-1:0]  rad_in, rad_next;
        logic [SIDE_W-1:0] side_k;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign side_k  = side_in;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_k  = side_reg[k-1];
        end

        always_comb begin
            rem_sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial     = {1'b0, root_in, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[ROOT_W-2:0], ge};
            rad_next  = rad_in << 2;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= side_k;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ROOT_W-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

// ===== src/htt_div.sv =====
module htt_div #(
    parameter int LANES  = htt_pkg::AXES,
    parameter int NUM_W  = htt_pkg::NUM_W,
    parameter int DEN_W  = htt_pkg::DIST_W,
    parameter int QUO_W  = htt_pkg::QUO_W,
    parameter int SIDE_W = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [LANES*NUM_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output logic [LANES*QUO_W-1:0] quo,
    output logic [SIDE_W-1:0]      side_out
);
    // numerator must stay below den * 2^QUO_W
    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0]  rem_reg  [QUO_W][LANES];
    logic [QUO_W-1:0]  low_reg  [QUO_W][LANES];
    logic [QUO_W-1:0]  q_reg    [QUO_W][LANES];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic [QUO_W-1:0]  valid_reg;

    // one quotient bit per stage, all lanes share the divisor
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [REM_W-1:0]  rem_in   [LANES];
        logic [QUO_W-1:0]  low_in   [LANES];
        logic [QUO_W-1:0]  q_in     [LANES];
        logic [REM_W-1:0]  rem_next [LANES];
        logic [QUO_W-1:0]  low_next [LANES];
        logic [QUO_W-1:0]  q_next   [LANES];
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_k;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = REM_W'(num[l*NUM_W+QUO_W +: NUM_W-QUO_W]);
                    low_in[l] = num[l*NUM_W +: QUO_W];
                    q_in[l]   = '0;
                end
            end
            assign den_in = den;
            assign side_k = side_in;
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = rem_reg[k-1][l];
                    low_in[l] = low_reg[k-1][l];
                    q_in[l]   = q_reg[k-1][l];
                end
            end
            assign den_in = den_reg[k-1];
            assign side_k = side_reg[k-1];
        end

        always_comb begin
            logic [REM_W-1:0] rem_sh;
            logic             ge;
            for (int l = 0; l < LANES; l++) begin
                rem_sh      = {rem_in[l][REM_W-2:0], low_in[l][QUO_W-1]};
                ge          = (rem_sh >= REM_W'(den_in));
                rem_next[l] = ge ? (rem_sh - REM_W'(den_in)) : rem_sh;
                q_next[l]   = {q_in[l][QUO_W-2:0], ge};
                low_next[l] = low_in[l] << 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k][l] <= rem_next[l];
                    low_reg[k][l] <= low_next[l];
                    q_reg[k][l]   <= q_next[l];
                end
                den_reg[k]  <= den_in;
                side_reg[k] <= side_k;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[QUO_W-2:0], in_valid};
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quo[l*QUO_W +: QUO_W] = q_reg[QUO_W-1][l];
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

// ===== src/homogeneous_travel_time_and_gradient_unit.sv =====
// throughput: one item per clock, back to back, sustained while m_tready stays high
// path: an accepted item runs through the pipeline stages, then the output register
//   (5 setup stages, 43 square-root stages, 32 divider stages, 3 finishing stages)
// a two-entry output (register plus skid) keeps the pipe moving while m_tready is low until the skid fills;
//   s_tready drops only while the skid entry is occupied
// reset: aresetn synchronous, active low; clears valid bits, source 0, spacing 1.0, slowness 0
`include "homogeneous_travel_time_and_gradient_unit_macros.svh"

module homogeneous_travel_time_and_gradient_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // node_x, node_y, node_z, zero pad
    input  logic [htt_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // travel_time, grad_x, grad_y, grad_z, zero pad
    output logic [htt_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [htt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [htt_pkg::REG_W-1:0]       cfg_wdata
);
    import htt_pkg::*;

    localparam int SQ_SIDE_W  = AXES * NUM_W + AXES;
    localparam int DIV_SIDE_W = DIST_W + AXES;

    // configuration registers
    logic [REG_W-1:0] src_reg [AXES];
    logic [REG_W-1:0] spc_reg [AXES];
    logic [REG_W-1:0] slow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                src_reg[a] <= '0;
                spc_reg[a] <= SPACING_RESET;
            end
            slow_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SRC_X:    src_reg[0] <= cfg_wdata;
                CFG_SRC_Y:    src_reg[1] <= cfg_wdata;
                CFG_SRC_Z:    src_reg[2] <= cfg_wdata;
                CFG_SPC_X:    spc_reg[0] <= cfg_wdata;
                CFG_SPC_Y:    spc_reg[1] <= cfg_wdata;
                CFG_SPC_Z:    spc_reg[2] <= cfg_wdata;
                CFG_SLOWNESS: slow_reg   <= cfg_wdata;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // whole pipe advances together; it halts only while the skid entry is full
    logic adv;
    logic skid_valid_reg, skid_valid_next;
    assign adv      = ~skid_valid_reg;
    assign s_tready = adv;

    // setup stage valid bits, bit k is stage k+1
    logic [4:0] pv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (adv) begin
            pv_reg <= {pv_reg[3:0], s_tvalid};
        end
    end

    // stage 1: clamp index, node position = index * spacing
    logic [POS_W-1:0] p1_pos_next [AXES];
    logic [POS_W-1:0] p1_pos_reg  [AXES];

    always_comb begin
        logic [IDX_W-1:0] idx;
        for (int a = 0; a < AXES; a++) begin
            idx = s_tdata[a*IDX_W +: IDX_W];
            if (32'(idx) > 32'(GRID_DIM_MAX - 1)) begin
                idx = IDX_W'(GRID_DIM_MAX - 1);
            end
            p1_pos_next[a] = POS_W'(idx) * POS_W'(spc_reg[a]);
        end
    end

    // stage 2: offset magnitude and sign
    logic [POS_W-1:0] p2_mag_next [AXES];
    logic [POS_W-1:0] p2_mag_reg  [AXES];
    logic [AXES-1:0]  p2_neg_next, p2_neg_reg;

    always_comb begin
        logic [POS_W-1:0] src;
        for (int a = 0; a < AXES; a++) begin
            src            = POS_W'(src_reg[a]);
            p2_neg_next[a] = (p1_pos_reg[a] < src);
            p2_mag_next[a] = p2_neg_next[a] ? (src - p1_pos_reg[a]) : (p1_pos_reg[a] - src);
        end
    end

    // stage 3: split partial products for the squares and the gradient numerators
    logic [2*SPLIT_W-1:0]     p3_ll_next  [AXES];
    logic [2*SPLIT_W-1:0]     p3_ll_reg   [AXES];
    logic [HI_W+SPLIT_W-1:0]  p3_hl_next  [AXES];
    logic [HI_W+SPLIT_W-1:0]  p3_hl_reg   [AXES];
    logic [2*HI_W-1:0]        p3_hh_next  [AXES];
    logic [2*HI_W-1:0]        p3_hh_reg   [AXES];
    logic [SPLIT_W+REG_W-1:0] p3_nlo_next [AXES];
    logic [SPLIT_W+REG_W-1:0] p3_nlo_reg  [AXES];
    logic [HI_W+REG_W-1:0]    p3_nhi_next [AXES];
    logic [HI_W+REG_W-1:0]    p3_nhi_reg  [AXES];
    logic [AXES-1:0]          p3_neg_reg;

    always_comb begin
        logic [SPLIT_W-1:0] lo;
        logic [HI_W-1:0]    hi;
        for (int a = 0; a < AXES; a++) begin
            lo             = p2_mag_reg[a][SPLIT_W-1:0];
            hi             = p2_mag_reg[a][POS_W-1:SPLIT_W];
            p3_ll_next[a]  = (2*SPLIT_W)'(lo) * (2*SPLIT_W)'(lo);
            p3_hl_next[a]  = (HI_W+SPLIT_W)'(hi) * (HI_W+SPLIT_W)'(lo);
            p3_hh_next[a]  = (2*HI_W)'(hi) * (2*HI_W)'(hi);
            p3_nlo_next[a] = (SPLIT_W+REG_W)'(lo) * (SPLIT_W+REG_W)'(slow_reg);
            p3_nhi_next[a] = (HI_W+REG_W)'(hi) * (HI_W+REG_W)'(slow_reg);
        end
    end

    // stage 4: assemble square and numerator per axis
    logic [SQ_W-1:0]  p4_sq_next  [AXES];
    logic [SQ_W-1:0]  p4_sq_reg   [AXES];
    logic [NUM_W-1:0] p4_num_next [AXES];
    logic [NUM_W-1:0] p4_num_reg  [AXES];
    logic [AXES-1:0]  p4_neg_reg;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            p4_sq_next[a]  = SQ_W'(p3_ll_reg[a])
                           + (SQ_W'(p3_hl_reg[a]) << (SPLIT_W + 1))
                           + (SQ_W'(p3_hh_reg[a]) << (2 * SPLIT_W));
            p4_num_next[a] = NUM_W'(p3_nlo_reg[a]) + (NUM_W'(p3_nhi_reg[a]) << SPLIT_W);
        end
    end

    // stage 5: sum of squares
    logic [SUM_W-1:0] p5_sum_next, p5_sum_reg;
    logic [NUM_W-1:0] p5_num_reg [AXES];
    logic [AXES-1:0]  p5_neg_reg;

    assign p5_sum_next = SUM_W'(p4_sq_reg[0]) + SUM_W'(p4_sq_reg[1]) + SUM_W'(p4_sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < AXES; a++) begin
                p1_pos_reg[a] <= p1_pos_next[a];
                p2_mag_reg[a] <= p2_mag_next[a];
                p3_ll_reg[a]  <= p3_ll_next[a];
                p3_hl_reg[a]  <= p3_hl_next[a];
                p3_hh_reg[a]  <= p3_hh_next[a];
                p3_nlo_reg[a] <= p3_nlo_next[a];
                p3_nhi_reg[a] <= p3_nhi_next[a];
                p4_sq_reg[a]  <= p4_sq_next[a];
                p4_num_reg[a] <= p4_num_next[a];
                p5_num_reg[a] <= p4_num_reg[a];
            end
            p2_neg_reg <= p2_neg_next;
            p3_neg_reg <= p2_neg_reg;
            p4_neg_reg <= p3_neg_reg;
            p5_neg_reg <= p4_neg_reg;
            p5_sum_reg <= p5_sum_next;
        end
    end

    // distance = floor(sqrt(sum)), numerators and signs ride alongside
    logic [SQ_SIDE_W-1:0] sq_side_in, sq_side_out;
    logic                 sq_valid;
    logic [DIST_W-1:0]    node_dist;

    assign sq_side_in = {p5_num_reg[2], p5_num_reg[1], p5_num_reg[0], p5_neg_reg};

    htt_isqrt #(
        .RAD_W  (SUM_W),
        .ROOT_W (DIST_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (pv_reg[4]),
        .radicand  (p5_sum_reg),
        .side_in   (sq_side_in),
        .out_valid (sq_valid),
        .root      (node_dist),
        .side_out  (sq_side_out)
    );

    // gradient divisor: zero distance raised to one lsb
    logic [DIST_W-1:0]     gdist;
    logic [DIV_SIDE_W-1:0] div_side_in, div_side_out;
    logic                  div_valid;
    logic [AXES*QUO_W-1:0] quo;
    logic [DIST_W-1:0]     div_dist;
    logic [AXES-1:0]       div_neg;

    assign gdist       = (node_dist == '0) ? DIST_W'(1) : node_dist;
    assign div_side_in = {node_dist, sq_side_out[AXES-1:0]};

    htt_div #(
        .LANES  (AXES),
        .NUM_W  (NUM_W),
        .DEN_W  (DIST_W),
        .QUO_W  (QUO_W),
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_valid),
        .num       (sq_side_out[SQ_SIDE_W-1:AXES]),
        .den       (gdist),
        .side_in   (div_side_in),
        .out_valid (div_valid),
        .quo       (quo),
        .side_out  (div_side_out)
    );

    assign div_dist = div_side_out[DIV_SIDE_W-1:AXES];
    assign div_neg  = div_side_out[AXES-1:0];

    // finishing stages: travel time product, gradient sign, packing
    logic [2:0]               tv_reg;
    logic [SPLIT_W+REG_W-1:0] t1_plo_next, t1_plo_reg;
    logic [DHI_W+REG_W-1:0]   t1_phi_next, t1_phi_reg;
    logic [GRAD_W-1:0]        t1_grad_next [AXES];
    logic [GRAD_W-1:0]        t1_grad_reg  [AXES];
    logic [TT_PROD_W-1:0]     t2_prod_next, t2_prod_reg;
    logic [GRAD_W-1:0]        t2_grad_reg  [AXES];
    logic [OUT_DATA_W-1:0]    t3_data_next, t3_data_reg;

    always_comb begin
        logic [GRAD_W-1:0] mag;
        t1_plo_next = (SPLIT_W+REG_W)'(div_dist[SPLIT_W-1:0]) * (SPLIT_W+REG_W)'(slow_reg);
        t1_phi_next = (DHI_W+REG_W)'(div_dist[DIST_W-1:SPLIT_W]) * (DHI_W+REG_W)'(slow_reg);
        for (int a = 0; a < AXES; a++) begin
            mag             = GRAD_W'(quo[a*QUO_W +: QUO_W]);
            t1_grad_next[a] = div_neg[a] ? (~mag + GRAD_W'(1)) : mag;
        end
    end

    assign t2_prod_next = TT_PROD_W'(t1_plo_reg) + (TT_PROD_W'(t1_phi_reg) << SPLIT_W);

    always_comb begin
        logic [TT_PROD_W-1:0] tt_full;
        logic [TT_W-1:0]      tt;
        tt_full = t2_prod_reg >> TT_SHIFT;
        // saturate anything past Q32.16
        if (|tt_full[TT_PROD_W-1:TT_W]) begin
            tt = '1;
        end else begin
            tt = tt_full[TT_W-1:0];
        end
        t3_data_next = OUT_DATA_W'({t2_grad_reg[2], t2_grad_reg[1], t2_grad_reg[0], tt});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= '0;
        end else if (adv) begin
            tv_reg <= {tv_reg[1:0], div_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_plo_reg  <= t1_plo_next;
            t1_phi_reg  <= t1_phi_next;
            t2_prod_reg <= t2_prod_next;
            for (int a = 0; a < AXES; a++) begin
                t1_grad_reg[a] <= t1_grad_next[a];
                t2_grad_reg[a] <= t1_grad_reg[a];
            end
            t3_data_reg <= t3_data_next;
        end
    end

    // output register plus skid entry
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_DATA_W-1:0] skid_data_reg, skid_data_next;
    logic                  out_take;

    always_comb begin
        out_take        = ~out_valid_reg | m_tready;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (tv_reg[2]) begin
            if (out_take) begin
                out_data_next  = t3_data_reg;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = t3_data_reg;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // the skid entry only fills behind a waiting output item
    `HTT_ASSERT_SAME(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid item with empty output register")
    `HTT_ASSERT_SAME(a_skid_fill_on_stall, aclk, aresetn, $rose(skid_valid_reg), $past(out_valid_reg && !m_tready), "skid filled without an output stall")
    // a positive x gradient component never exceeds the slowness
    `HTT_ASSERT_SAME(a_grad_x_bound, aclk, aresetn, out_valid_reg && !m_tdata[TT_W+GRAD_W-1], m_tdata[TT_W +: REG_W] <= slow_reg, "grad_x magnitude above slowness")

endmodule
